/* hdl/mkcd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_pkg
// Shared types, field widths and codes of the multi-board key debouncer.
// ---------------------------------------------------------------------------
package mkcd_pkg;

  // Default geometry
  localparam int unsigned DEF_BOARDS         = 2;
  localparam int unsigned DEF_ROWS           = 8;
  localparam int unsigned DEF_BOARD_COLUMNS  = 8;
  localparam int unsigned DEF_KEYS_PER_BOARD = 64;

  // Request / response field widths
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned BOARD_W      = 1;
  localparam int unsigned LOCAL_KEY_W  = 6;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned GLOBAL_KEY_W = 7;

  // Counter and configuration
  localparam int unsigned COUNT_W      = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned THRESH_W     = 8;
  localparam int unsigned WARM_FRM_W   = 8;
  localparam int unsigned WARM_MS_W    = 16;

  localparam logic [THRESH_W-1:0]   DEF_THRESHOLD = 8'd3;
  localparam logic [WARM_FRM_W-1:0] DEF_WARM_FRM  = 8'd2;
  localparam logic [WARM_MS_W-1:0]  DEF_WARM_MS   = 16'd100;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ONLINE  = 2'd1,
    OP_OFFLINE = 2'd2,
    OP_FRAME   = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WARM_FRM  = 2'd1,
    CFG_WARM_MS   = 2'd2
  } cfg_idx_e;

  // Per-key debounce state, one memory word
  typedef struct packed {
    logic               stable;
    logic               cand;
    logic [COUNT_W-1:0] count;
  } key_entry_t;

endpackage

`default_nettype wire

/* hdl/mkcd_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_in_if / mkcd_out_if
// Valid/ready channels carrying debouncer requests and responses.
// ---------------------------------------------------------------------------
interface mkcd_in_if
  import mkcd_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [BOARD_W-1:0]     board;
  logic [LOCAL_KEY_W-1:0] local_key;
  logic                   raw_pressed;
  logic [TIME_W-1:0]      now_ms;

  modport source (output valid, opcode, board, local_key, raw_pressed, now_ms,
                  input ready);
  modport sink   (input valid, opcode, board, local_key, raw_pressed, now_ms,
                  output ready);
endinterface

interface mkcd_out_if
  import mkcd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [GLOBAL_KEY_W-1:0] global_key;
  logic                    stable_level;
  logic                    press_edge;
  logic                    release_edge;
  logic                    sample_used;
  logic                    board_online;

  modport source (output valid, global_key, stable_level, press_edge, release_edge,
                  sample_used, board_online, input ready);
  modport sink   (input valid, global_key, stable_level, press_edge, release_edge,
                  sample_used, board_online, output ready);
endinterface

`default_nettype wire

/* hdl/mkcd_key_store.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_key_store
// Per-key state memory: registered read, write-through forwarding, and
// per-entry valid bits so a whole board clears at once.
// ---------------------------------------------------------------------------
module mkcd_key_store
  import mkcd_pkg::*;
#(
  parameter int unsigned TOTAL_KEYS = 128,
  parameter int unsigned BLOCK_KEYS = 64,
  parameter int unsigned BOARD_AW   = 1,
  parameter int unsigned KEY_AW     = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [KEY_AW-1:0]   rd_addr_i,
  output key_entry_t               rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [KEY_AW-1:0]   wr_addr_i,
  input  wire key_entry_t          wr_data_i,
  input  wire logic                clr_en_i,
  input  wire logic [BOARD_AW-1:0] clr_board_i
);

  key_entry_t             mem [TOTAL_KEYS];
  key_entry_t             rdata_q;
  logic [KEY_AW-1:0]      rd_addr_q;
  logic                   fwd_hit_q;
  key_entry_t             fwd_data_q;
  logic [TOTAL_KEYS-1:0]  valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // A write landing on the same edge as the read is missed by the array.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      rd_addr_q <= '0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  for (genvar g = 0; g < TOTAL_KEYS; g++) begin : g_valid
    localparam int unsigned OWNER = g / BLOCK_KEYS;
    assign valid_d[g] = (clr_en_i && (32'(clr_board_i) == OWNER)) ? 1'b0 :
                        (wr_en_i && (32'(wr_addr_i) == g))        ? 1'b1 :
                        valid_q[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (valid_q[rd_addr_q]) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

/* hdl/multi_key_counter_debouncer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// multi_key_counter_debouncer
// Counter-based key debouncer over several scan boards, with board
// online/offline handling and a frame and time based warmup window.
// ---------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Carries
//  in_i      in    valid/ready        opcode, board, local_key, raw_pressed, now_ms
//  out_o     out   valid/ready        global_key, levels, edges, used, online
//  cfg       in    cfg_we_i only      cfg_idx_i, cfg_data_i (no read-back)
//
//  One request per cycle sustained while the output side does not stall;
//  each accepted request passes key memory read, then modify/write + out reg.
//  Reset: valid bits wipe all key state at once, so no clearing pass.
//  A full output register stalls the update stage, which in turn drops
//  in_i.ready; the update stage and output register keep requests in order.
//
module multi_key_counter_debouncer
  import mkcd_pkg::*;
#(
  parameter int unsigned BOARDS         = DEF_BOARDS,
  parameter int unsigned ROWS           = DEF_ROWS,
  parameter int unsigned BOARD_COLUMNS  = DEF_BOARD_COLUMNS,
  parameter int unsigned KEYS_PER_BOARD = DEF_KEYS_PER_BOARD
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mkcd_in_if.sink                    in_i,
  mkcd_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Keys of one board in grid order: column * ROWS + row
  localparam int unsigned BLOCK_KEYS = BOARD_COLUMNS * ROWS;
  localparam int unsigned TOTAL_KEYS = BOARDS * BLOCK_KEYS;
  localparam int unsigned KEY_AW     = (TOTAL_KEYS > 1) ? $clog2(TOTAL_KEYS) : 1;
  localparam int unsigned BOARD_AW   = (BOARDS > 1) ? $clog2(BOARDS) : 1;

  // ---------------- configuration registers ----------------
  logic [THRESH_W-1:0]   thresh_q;
  logic [WARM_FRM_W-1:0] warm_frm_q;
  logic [WARM_MS_W-1:0]  warm_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= DEF_THRESHOLD;
      warm_frm_q <= DEF_WARM_FRM;
      warm_ms_q  <= DEF_WARM_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: thresh_q   <= cfg_data_i[THRESH_W-1:0];
        CFG_WARM_FRM:  warm_frm_q <= cfg_data_i[WARM_FRM_W-1:0];
        CFG_WARM_MS:   warm_ms_q  <= cfg_data_i[WARM_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic accept;

  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept    = in_i.valid && in_i.ready;

  // ---------------- accept stage: key mapping ----------------
  // local_key = column * ROWS + row, so the column bound is local < BLOCK_KEYS
  logic              in_key_ok;
  logic              in_board_ok;
  logic [31:0]       in_gkey_wide;
  logic [KEY_AW-1:0] in_gkey;

  assign in_board_ok  = 32'(in_i.board) < BOARDS;
  assign in_key_ok    = (32'(in_i.local_key) < KEYS_PER_BOARD) &&
                        (32'(in_i.local_key) < BLOCK_KEYS);
  assign in_gkey_wide = 32'(in_i.board) * BLOCK_KEYS + 32'(in_i.local_key);
  assign in_gkey      = in_gkey_wide[KEY_AW-1:0];

  logic [OPCODE_W-1:0] s1_op_q;
  logic [BOARD_AW-1:0] s1_board_q;
  logic                s1_board_ok_q;
  logic                s1_key_ok_q;
  logic                s1_raw_q;
  logic [TIME_W-1:0]   s1_now_q;
  logic [KEY_AW-1:0]   s1_gkey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= in_i.opcode;
      s1_board_q    <= BOARD_AW'(in_i.board);
      s1_board_ok_q <= in_board_ok;
      s1_key_ok_q   <= in_key_ok;
      s1_raw_q      <= in_i.raw_pressed;
      s1_now_q      <= in_i.now_ms;
      s1_gkey_q     <= in_gkey;
    end
  end

  // ---------------- key memory ----------------
  key_entry_t        cur_entry;
  key_entry_t        new_entry;
  logic              key_wr;
  logic              key_clr;

  mkcd_key_store #(
    .TOTAL_KEYS (TOTAL_KEYS),
    .BLOCK_KEYS (BLOCK_KEYS),
    .BOARD_AW   (BOARD_AW),
    .KEY_AW     (KEY_AW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (in_gkey),
    .rd_data_o   (cur_entry),
    .wr_en_i     (key_wr),
    .wr_addr_i   (s1_gkey_q),
    .wr_data_i   (new_entry),
    .clr_en_i    (key_clr),
    .clr_board_i (s1_board_q)
  );

  // ---------------- board state ----------------
  logic                  online_q   [BOARDS];
  logic [WARM_FRM_W-1:0] frames_q   [BOARDS];
  logic [TIME_W-1:0]     deadline_q [BOARDS];
  logic                  skip_q     [BOARDS];

  logic                  b_online, b_skip;
  logic [WARM_FRM_W-1:0] b_frames;
  logic [TIME_W-1:0]     b_deadline;

  // Out-of-range board index only reached when s1_board_ok_q is low
  assign b_online   = s1_board_ok_q ? online_q[s1_board_q]   : 1'b0;
  assign b_skip     = s1_board_ok_q ? skip_q[s1_board_q]     : 1'b1;
  assign b_frames   = s1_board_ok_q ? frames_q[s1_board_q]   : '0;
  assign b_deadline = s1_board_ok_q ? deadline_q[s1_board_q] : '0;

  logic                  nb_we;
  logic                  nb_online, nb_skip;
  logic [WARM_FRM_W-1:0] nb_frames;
  logic [TIME_W-1:0]     nb_deadline;

  // ---------------- update stage ----------------
  logic              r_stable, r_press, r_release, r_used;
  logic [COUNT_W-1:0] cnt_next;
  logic              warm;

  always_comb begin
    new_entry   = cur_entry;
    key_wr      = 1'b0;
    key_clr     = 1'b0;
    nb_we       = 1'b0;
    nb_online   = b_online;
    nb_skip     = b_skip;
    nb_frames   = b_frames;
    nb_deadline = b_deadline;
    r_stable    = 1'b0;
    r_press     = 1'b0;
    r_release   = 1'b0;
    r_used      = 1'b0;
    cnt_next    = '0;
    warm        = 1'b0;

    if (s1_board_ok_q) begin
      case (opcode_e'(s1_op_q))
        OP_SAMPLE: begin
          if (s1_key_ok_q) begin
            if (b_online && !b_skip) begin
              r_used = 1'b1;
              key_wr = s1_adv;
              if (s1_raw_q == cur_entry.stable) begin
                new_entry.count = '0;
              end else begin
                if (s1_raw_q == cur_entry.cand) begin
                  cnt_next = (cur_entry.count == COUNT_MAX) ? cur_entry.count :
                             cur_entry.count + COUNT_W'(1);
                end else begin
                  cnt_next = COUNT_W'(1);
                end
                new_entry.cand  = s1_raw_q;
                new_entry.count = cnt_next;
                // threshold of zero behaves as one: count is at least one here
                if (cnt_next >= thresh_q) begin
                  new_entry.stable = s1_raw_q;
                  new_entry.count  = '0;
                  r_press          = s1_raw_q;
                  r_release        = !s1_raw_q;
                end
              end
            end
            r_stable = new_entry.stable;
          end
        end
        OP_ONLINE: begin
          if (!b_online) begin
            nb_we       = 1'b1;
            nb_online   = 1'b1;
            nb_frames   = warm_frm_q;
            nb_deadline = s1_now_q + TIME_W'(warm_ms_q);
            nb_skip     = 1'b1;
            key_clr     = s1_adv;
          end
        end
        OP_OFFLINE: begin
          nb_we       = 1'b1;
          nb_online   = 1'b0;
          nb_frames   = '0;
          nb_deadline = '0;
          nb_skip     = 1'b1;
          key_clr     = s1_adv;
        end
        OP_FRAME: begin
          nb_we = 1'b1;
          if (!b_online) begin
            nb_skip = 1'b1;
          end else begin
            warm    = (b_frames != '0) || (s1_now_q < b_deadline);
            nb_skip = warm;
            if (b_frames != '0) begin
              nb_frames = b_frames - WARM_FRM_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BOARDS; b++) begin
        online_q[b]   <= 1'b0;
        frames_q[b]   <= '0;
        deadline_q[b] <= '0;
        skip_q[b]     <= 1'b1;
      end
    end else if (s1_adv && nb_we) begin
      online_q[s1_board_q]   <= nb_online;
      frames_q[s1_board_q]   <= nb_frames;
      deadline_q[s1_board_q] <= nb_deadline;
      skip_q[s1_board_q]     <= nb_skip;
    end
  end

  // ---------------- output register ----------------
  logic [31:0] gkey_wide;
  assign gkey_wide = 32'(s1_gkey_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_o.global_key   <= (s1_board_ok_q && s1_key_ok_q &&
                             (opcode_e'(s1_op_q) == OP_SAMPLE)) ?
                            gkey_wide[GLOBAL_KEY_W-1:0] : '0;
      out_o.stable_level <= r_stable;
      out_o.press_edge   <= r_press;
      out_o.release_edge <= r_release;
      out_o.sample_used  <= r_used;
      out_o.board_online <= s1_board_ok_q ? nb_online : 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

/* tb/sv/tb_multi_key_counter_debouncer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_key_counter_debouncer
// Self-checking bench for the multi-board key debouncer. A scoreboard
// mirrors the per-key and per-board state, predicts one response for each
// accepted request and compares it with what the block returns. A short
// directed sequence is followed by board sessions (online, warmup frames,
// bouncing key scans, offline) mixed with random noise, under several
// register settings and with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_multi_key_counter_debouncer;
  import mkcd_pkg::*;

  localparam int unsigned KEYS_TOTAL   = DEF_BOARDS * DEF_BOARD_COLUMNS * DEF_ROWS;
  localparam int unsigned DRAIN_CYCLES = 6;       // extra wait after the last response
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  // Register index with no register behind it; writes must be harmless
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // One request on the input channel
  typedef struct packed {
    opcode_e                op;
    logic [BOARD_W-1:0]     board;
    logic [LOCAL_KEY_W-1:0] lkey;
    logic                   raw;
    logic [TIME_W-1:0]      now;
  } key_event_t;

  // One response on the output channel
  typedef struct packed {
    logic [GLOBAL_KEY_W-1:0] gkey;
    logic                    stable;
    logic                    press;
    logic                    rel;
    logic                    used;
    logic                    onl;
  } key_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow copy of the debouncer state plus expected responses
  // -------------------------------------------------------------------------
  class key_debounce_scoreboard;
    logic                  stable_lvl [KEYS_TOTAL];
    logic                  cand_lvl   [KEYS_TOTAL];
    logic [COUNT_W-1:0]    cand_cnt   [KEYS_TOTAL];
    logic                  online     [DEF_BOARDS];
    logic [WARM_FRM_W-1:0] frames_left[DEF_BOARDS];
    logic [TIME_W-1:0]     deadline   [DEF_BOARDS];
    logic                  skip_frame [DEF_BOARDS];
    logic [THRESH_W-1:0]   thresh;
    logic [WARM_FRM_W-1:0] warm_frm;
    logic [WARM_MS_W-1:0]  warm_ms;
    key_result_t           expected_results[$];
    int unsigned           mismatches;

    function new();
      thresh     = DEF_THRESHOLD;
      warm_frm   = DEF_WARM_FRM;
      warm_ms    = DEF_WARM_MS;
      mismatches = 0;
      for (int i = 0; i < KEYS_TOTAL; i++) begin
        stable_lvl[i] = 1'b0;
        cand_lvl[i]   = 1'b0;
        cand_cnt[i]   = '0;
      end
      for (int b = 0; b < DEF_BOARDS; b++) begin
        online[b]      = 1'b0;
        frames_left[b] = '0;
        deadline[b]    = '0;
        skip_frame[b]  = 1'b1;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_THRESHOLD)     thresh   = data[THRESH_W-1:0];
      else if (idx == CFG_WARM_FRM) warm_frm = data[WARM_FRM_W-1:0];
      else if (idx == CFG_WARM_MS)  warm_ms  = data[WARM_MS_W-1:0];
    endfunction

    function void clear_board(int unsigned b);
      for (int k = 0; k < DEF_KEYS_PER_BOARD; k++) begin
        stable_lvl[b * DEF_KEYS_PER_BOARD + k] = 1'b0;
        cand_lvl[b * DEF_KEYS_PER_BOARD + k]   = 1'b0;
        cand_cnt[b * DEF_KEYS_PER_BOARD + k]   = '0;
      end
    endfunction

    // Apply an accepted request to the shadow state, queue its response
    function void note_request(key_event_t r);
      key_result_t res;
      int unsigned b, col, row, g;
      logic        warm;
      res = '0;
      b   = r.board;
      case (r.op)
        OP_SAMPLE: begin
          col = r.lkey / DEF_ROWS;
          row = r.lkey % DEF_ROWS;
          if (r.lkey < DEF_KEYS_PER_BOARD && col < DEF_BOARD_COLUMNS) begin
            g        = (b * DEF_BOARD_COLUMNS + col) * DEF_ROWS + row;
            res.gkey = g[GLOBAL_KEY_W-1:0];
            if (online[b] && !skip_frame[b]) begin
              res.used = 1'b1;
              if (r.raw == stable_lvl[g]) begin
                cand_cnt[g] = '0;
              end else begin
                if (r.raw == cand_lvl[g]) begin
                  if (cand_cnt[g] != COUNT_MAX) cand_cnt[g] = cand_cnt[g] + 1'b1;
                end else begin
                  cand_lvl[g] = r.raw;
                  cand_cnt[g] = 8'd1;
                end
                // a zero threshold behaves like one
                if (cand_cnt[g] >= thresh) begin
                  stable_lvl[g] = r.raw;
                  cand_cnt[g]   = '0;
                  res.press     = r.raw;
                  res.rel       = ~r.raw;
                end
              end
            end
            res.stable = stable_lvl[g];
          end
        end
        OP_ONLINE: begin
          if (!online[b]) begin
            online[b]      = 1'b1;
            frames_left[b] = warm_frm;
            deadline[b]    = r.now + {16'd0, warm_ms};
            skip_frame[b]  = 1'b1;
            clear_board(b);
          end
        end
        OP_OFFLINE: begin
          online[b]      = 1'b0;
          frames_left[b] = '0;
          deadline[b]    = '0;
          skip_frame[b]  = 1'b1;
          clear_board(b);
        end
        default: begin
          if (!online[b]) begin
            skip_frame[b] = 1'b1;
          end else begin
            warm = (frames_left[b] != 0) || (r.now < deadline[b]);
            if (frames_left[b] != 0) frames_left[b] = frames_left[b] - 1'b1;
            skip_frame[b] = warm;
          end
        end
      endcase
      res.onl = online[b];
      expected_results.push_back(res);
    endfunction

    function void check_response(key_result_t got);
      key_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: response with none pending: key %0d lvl %0b", got.gkey, got.stable);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: key exp %0d act %0d | lvl %0b/%0b press %0b/%0b rel %0b/%0b",
                   want.gkey, got.gkey, want.stable, got.stable, want.press, got.press,
                   want.rel, got.rel, " used %0b/%0b online %0b/%0b",
                   want.used, got.used, want.onl, got.onl);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the block under test
  // -------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mkcd_in_if  in_if ();
  mkcd_out_if out_if ();

  multi_key_counter_debouncer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  key_debounce_scoreboard sb;
  key_event_t             request_queue[$];
  logic [TIME_W-1:0]      board_ms[DEF_BOARDS];   // per-board scan clock for sessions
  int unsigned            idle_pct;               // sender idle chance, percent
  int unsigned            stall_pct;              // receiver stall chance, percent
  logic                   hold_off;               // long receiver hold for back-pressure
  int unsigned            cycle_cnt;

  // Watchdog: a hung handshake or a lost response ends the run here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Response side: check on every handshake, then pick next ready level.
  // Values read here are the pre-edge ones, so no ordering race with the block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_response(key_result_t'{out_if.global_key, out_if.stable_level,
                                        out_if.press_edge, out_if.release_edge,
                                        out_if.sample_used, out_if.board_online});
      if (hold_off) out_if.ready <= 1'b0;
      else          out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic add_event(opcode_e op, logic [BOARD_W-1:0] b, logic [LOCAL_KEY_W-1:0] k,
                           logic raw, logic [TIME_W-1:0] now);
    request_queue.push_back(key_event_t'{op, b, k, raw, now});
  endtask

  // Noise request: any opcode, any field value
  task automatic add_noise();
    add_event(opcode_e'($urandom_range(3)), BOARD_W'($urandom_range(1)),
              LOCAL_KEY_W'($urandom_range(63)), 1'($urandom_range(1)), $urandom);
  endtask

  // Well-formed board session: online, warmup frames, deadline crossing,
  // then scan frames with a few keys bouncing around a target level.
  task automatic queue_session(int unsigned scan_frames);
    logic [BOARD_W-1:0]     b;
    logic [TIME_W-1:0]      t, dl;
    logic [LOCAL_KEY_W-1:0] keys[3];
    logic                   lvl[3];
    int unsigned            nfrm, s;
    b = BOARD_W'($urandom_range(1));
    if ($urandom_range(1)) add_event(OP_OFFLINE, b, LOCAL_KEY_W'($urandom_range(63)),
                                     1'($urandom_range(1)), $urandom);
    t = board_ms[b] + $urandom_range(40, 1);
    add_event(OP_ONLINE, b, LOCAL_KEY_W'($urandom_range(63)), 1'($urandom_range(1)), t);
    dl   = t + {16'd0, sb.warm_ms};
    nfrm = sb.warm_frm;
    // now and then one warmup frame short, so the scan frames start skipped
    if (nfrm != 0 && $urandom_range(9) < 2) nfrm = nfrm - 1;
    repeat (nfrm) begin
      t = t + $urandom_range(3);
      add_event(OP_FRAME, b, LOCAL_KEY_W'($urandom_range(63)), 1'($urandom_range(1)), t);
    end
    // mostly jump past the deadline; sometimes stay just short of it
    if (t < dl && $urandom_range(3) != 0) t = dl + $urandom_range(2);
    for (int j = 0; j < 3; j++) begin
      keys[j] = LOCAL_KEY_W'($urandom_range(63));
      lvl[j]  = 1'($urandom_range(1));
    end
    repeat (scan_frames) begin
      t = t + $urandom_range(5, 1);
      add_event(OP_FRAME, b, LOCAL_KEY_W'($urandom_range(63)), 1'($urandom_range(1)), t);
      repeat ($urandom_range(12, 4)) begin
        s = $urandom_range(2);
        if ($urandom_range(9) == 0) lvl[s] = ~lvl[s];
        add_event(OP_SAMPLE, b, keys[s],
                  ($urandom_range(99) < 85) ? lvl[s] : ~lvl[s], $urandom);
      end
    end
    if ($urandom_range(4) == 0) add_event(OP_OFFLINE, b, LOCAL_KEY_W'($urandom_range(63)),
                                          1'b0, $urandom);
    board_ms[b] = t;
  endtask

  // Sessions with some noise until the queue holds at least n requests
  task automatic queue_mix(int unsigned n);
    while (request_queue.size() < n) begin
      if ($urandom_range(99) < 15) add_noise();
      else                         queue_session($urandom_range(4, 1));
    end
  endtask

  // Offer queued requests; a held request stays on the bus until accepted
  task automatic drive_requests();
    key_event_t cur;
    bit         holding;
    holding = 1'b0;
    while (request_queue.size() != 0 || holding) begin
      @(posedge clk);
      if (holding && in_if.ready) begin
        sb.note_request(cur);
        holding = 1'b0;
      end
      if (!holding && request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur     = request_queue.pop_front();
        holding = 1'b1;
        in_if.valid       <= 1'b1;
        in_if.opcode      <= cur.op;
        in_if.board       <= cur.board;
        in_if.local_key   <= cur.lkey;
        in_if.raw_pressed <= cur.raw;
        in_if.now_ms      <= cur.now;
      end else if (!holding) begin
        in_if.valid <= 1'b0;
      end
    end
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the block captures it on the edge where we is high
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [THRESH_W-1:0] thr, logic [WARM_FRM_W-1:0] frm,
                            logic [WARM_MS_W-1:0] ms);
    write_reg(CFG_THRESHOLD, {8'd0, thr});
    write_reg(CFG_WARM_FRM, {8'd0, frm});
    write_reg(CFG_WARM_MS, ms);
  endtask

  task automatic set_idling(int unsigned idle, int unsigned stall);
    @(posedge clk);
    idle_pct  <= idle;
    stall_pct <= stall;
  endtask

  task automatic hold_receiver(int unsigned cycles);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_SAMPLE;
    in_if.board       = '0;
    in_if.local_key   = '0;
    in_if.raw_pressed = 1'b0;
    in_if.now_ms      = '0;
    out_if.ready      = 1'b0;
    hold_off          = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    cycle_cnt         = 0;
    board_ms[0]       = $urandom_range(32'h7FFF_FFFF);
    board_ms[1]       = $urandom_range(32'h7FFF_FFFF);
    sb                = new();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part, reset settings: threshold 3, 2 frames, 100 ms ---
    add_event(OP_SAMPLE,  1'b0, 6'd0,  1'b1, 32'd0);          // board offline: ignored
    add_event(OP_FRAME,   1'b0, 6'd0,  1'b0, 32'd7);          // frame on offline board
    add_event(OP_OFFLINE, 1'b1, 6'd63, 1'b0, 32'hFFFF_FFFF);  // offline while offline
    add_event(OP_ONLINE,  1'b0, 6'd0,  1'b0, 32'd1000);       // deadline 1100
    add_event(OP_ONLINE,  1'b0, 6'd0,  1'b0, 32'd5);          // online again: no effect
    add_event(OP_FRAME,   1'b0, 6'd0,  1'b0, 32'd1001);       // warmup frame
    add_event(OP_SAMPLE,  1'b0, 6'd63, 1'b1, 32'd0);          // skipped frame: ignored
    add_event(OP_FRAME,   1'b0, 6'd0,  1'b0, 32'd1002);       // last warmup frame
    add_event(OP_FRAME,   1'b0, 6'd0,  1'b0, 32'd1099);       // still before deadline
    add_event(OP_FRAME,   1'b0, 6'd0,  1'b0, 32'd1100);       // deadline met: live
    repeat (3) add_event(OP_SAMPLE, 1'b0, 6'd63, 1'b1, 32'd0); // press on the third
    add_event(OP_SAMPLE,  1'b0, 6'd63, 1'b0, 32'd0);          // new candidate
    add_event(OP_SAMPLE,  1'b0, 6'd63, 1'b1, 32'd0);          // back to stable: cleared
    add_event(OP_SAMPLE,  1'b0, 6'd0,  1'b0, 32'd0);          // equals stable
    add_event(OP_SAMPLE,  1'b0, 6'd0,  1'b1, 32'd0);          // bounce
    repeat (3) add_event(OP_SAMPLE, 1'b0, 6'd63, 1'b0, 32'd0); // release
    add_event(OP_ONLINE,  1'b1, 6'd0,  1'b0, 32'hFFFF_FFF0);  // deadline wraps to 0x54
    add_event(OP_FRAME,   1'b1, 6'd0,  1'b0, 32'hFFFF_FFF1);
    add_event(OP_FRAME,   1'b1, 6'd0,  1'b0, 32'hFFFF_FFF2);
    add_event(OP_FRAME,   1'b1, 6'd0,  1'b0, 32'hFFFF_FFF3);  // plain compare: live
    add_event(OP_SAMPLE,  1'b1, 6'd63, 1'b1, 32'hFFFF_FFFF);  // highest grid key
    add_event(OP_OFFLINE, 1'b0, 6'd0,  1'b0, 32'd0);          // clears board 0
    add_event(OP_SAMPLE,  1'b0, 6'd63, 1'b1, 32'd0);          // ignored again
    drive_requests();
    wait_drain();

    // --- fastest settings, no idling ---
    set_config(8'd1, 8'd0, 16'd0);
    set_idling(0, 0);
    queue_mix(60);
    drive_requests();
    wait_drain();

    // --- highest threshold and longest warmup time, sender idling ---
    set_config(8'd255, 8'd1, 16'hFFFF);
    set_idling(72, 0);
    add_event(OP_OFFLINE, 1'b0, 6'd0, 1'b0, 32'd0);
    add_event(OP_ONLINE,  1'b0, 6'd0, 1'b0, 32'd10);
    add_event(OP_FRAME,   1'b0, 6'd0, 1'b0, 32'd11);
    add_event(OP_FRAME,   1'b0, 6'd0, 1'b0, 32'd65545);        // exactly at the deadline
    repeat (256) add_event(OP_SAMPLE, 1'b0, 6'd5, 1'b1, $urandom); // press on 255th
    repeat (4)   add_event(OP_SAMPLE, 1'b0, 6'd5, 1'b0, $urandom);
    drive_requests();
    queue_mix(20);
    drive_requests();
    wait_drain();

    // --- threshold zero and more warmup frames (upper data bits set), receiver stalls ---
    write_reg(CFG_THRESHOLD, 16'hA500);
    write_reg(CFG_WARM_FRM, 16'h5A10);
    write_reg(CFG_WARM_MS, 16'd0);
    set_idling(0, 72);
    queue_mix(40);
    drive_requests();
    wait_drain();

    // --- moderate settings, both sides idling ---
    set_config(8'd4, 8'd3, 16'd50);
    set_idling(33, 33);
    queue_mix(30);
    drive_requests();
    wait_drain();

    // --- back-pressure: receiver held off while the sender keeps offering ---
    set_config(8'd2, 8'd1, 16'd10);
    set_idling(0, 0);
    queue_mix(60);
    fork
      hold_receiver(300);
      drive_requests();
    join
    wait_drain();                           // sender pauses until all responses are in
    set_idling(33, 72);
    queue_mix(20);
    drive_requests();
    wait_drain();

    // --- reset settings again, spare index written, heavy idling ---
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(16'hFFFF)));
    set_config(DEF_THRESHOLD, DEF_WARM_FRM, DEF_WARM_MS);
    set_idling(72, 72);
    queue_mix(30);
    drive_requests();
    wait_drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mkcd_pkg.sv
hdl/mkcd_if.sv
hdl/mkcd_key_store.sv
hdl/multi_key_counter_debouncer.sv
tb/sv/tb_multi_key_counter_debouncer.sv
